// ===== rtl/ansi_sgr_text_layout_macros.svh =====
`ifndef ANSI_SGR_TEXT_LAYOUT_MACROS_SVH
`define ANSI_SGR_TEXT_LAYOUT_MACROS_SVH

// Checks on the same cycle, sampled on clk, off while rst_n is low.
`define ASGR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asgr check failed");

// Consequent checked in the cycle after the antecedent.
`define ASGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asgr check failed");

`endif

// ===== rtl/asgr_pkg.sv =====
package asgr_pkg;

    localparam int unsigned CODE_W      = 21;
    localparam int unsigned ADV_W       = 16;
    localparam int unsigned PEN_X_W     = 22;
    localparam int unsigned PX_W        = 16;
    localparam int unsigned STYLE_W     = 2;
    localparam int unsigned COLOR_W     = 24;
    localparam int unsigned FONT_W      = 8;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    // character codes with a meaning of their own
    localparam logic [CODE_W-1:0] CH_TAB = 21'd9;
    localparam logic [CODE_W-1:0] CH_LF  = 21'd10;
    localparam logic [CODE_W-1:0] CH_VT  = 21'd11;
    localparam logic [CODE_W-1:0] CH_CR  = 21'd13;
    localparam logic [CODE_W-1:0] CH_ESC = 21'd27;
    localparam logic [CODE_W-1:0] CH_M   = 21'd109;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_INITIAL_STYLE,
        CFG_INITIAL_COLOR,
        CFG_FONT_SIZE_PX,
        CFG_WINDOW_WIDTH,
        CFG_WINDOW_HEIGHT,
        CFG_WRAP_ENABLE
    } cfg_index_t;

    typedef struct packed {
        logic [PX_W-1:0]    origin_x;
        logic [PX_W-1:0]    origin_y;
        logic [STYLE_W-1:0] initial_style;
        logic [COLOR_W-1:0] initial_color;
        logic [FONT_W-1:0]  font_size_px;
        logic [PX_W-1:0]    window_width;
        logic [PX_W-1:0]    window_height;
        logic               wrap_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        origin_x:      16'd0,
        origin_y:      16'd0,
        initial_style: 2'd0,
        initial_color: 24'd0,
        font_size_px:  8'd16,
        window_width:  16'd1024,
        window_height: 16'd768,
        wrap_enable:   1'b0
    };

    typedef enum logic [2:0] {
        SGR_NONE,
        SGR_RESET,
        SGR_BOLD,
        SGR_ITALIC,
        SGR_COLOR,
        SGR_NO_BOLD,
        SGR_NO_ITALIC,
        SGR_BAD
    } sgr_op_t;

    typedef struct packed {
        logic               busy;
        sgr_op_t            op;
        logic [COLOR_W-1:0] color;
    } esc_res_t;

    typedef struct packed {
        logic              start_of_string;
        logic [CODE_W-1:0] char_code;
        logic [ADV_W-1:0]  advance_regular;
        logic [ADV_W-1:0]  advance_bold;
        logic [ADV_W-1:0]  advance_italic;
        logic [ADV_W-1:0]  advance_bold_italic;
    } in_item_t;

    typedef struct packed {
        logic               draw_glyph;
        logic [PEN_X_W-1:0] pen_x;
        logic [PX_W-1:0]    pen_y;
        logic [STYLE_W-1:0] style;
        logic [COLOR_W-1:0] color;
        logic [PX_W-1:0]    area_right;
        logic [PX_W-1:0]    area_bottom;
        logic               stopped;
        logic               bad_sequence;
    } out_item_t;

endpackage

// ===== rtl/ansi_sgr_text_layout.sv =====
// Text layout with ANSI SGR escape handling. One character per cycle is
// taken on the item channel while item_stall is low, and each one gives
// exactly one result: it passes the input register, then the pen, style and
// escape update into the result register. The figure of one item a cycle is
// set by that state update, which every character reads and writes in turn.
// The item register lets a new character in while a result waits on a stalled
// result channel. cfg_ready is always high; registers are to be written only
// while no character is in flight. State starts at origin zero after reset and
// is reloaded from the registers by start_of_string.
module ansi_sgr_text_layout #(
    parameter int unsigned ESCAPE_BYTES = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  asgr_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output asgr_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [asgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [asgr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic               item_vld_reg;
    logic               item_vld_next;
    asgr_pkg::in_item_t item_reg;
    logic               res_vld_reg;
    logic               res_vld_next;
    logic               adv_out;
    logic               take;
    logic               fire;
    logic               run;
    asgr_pkg::cfg_t     regs;
    asgr_pkg::esc_res_t esc;

    always_comb
    begin
        adv_out       = !res_vld_reg || !result_stall;
        fire          = item_vld_reg && adv_out;
        item_stall    = item_vld_reg && !adv_out;
        take          = item_valid && !item_stall;
        item_vld_next = take || (item_vld_reg && !adv_out);
        res_vld_next  = adv_out ? item_vld_reg : res_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = res_vld_reg;

    asgr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .regs     (regs)
    );

    asgr_esc #(
        .ESCAPE_BYTES (ESCAPE_BYTES)
    ) u_esc (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .sos   (item_reg.start_of_string),
        .run   (run),
        .code  (item_reg.char_code),
        .res   (esc)
    );

    asgr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (regs),
        .esc    (esc),
        .run    (run),
        .result (result)
    );

endmodule

// ===== rtl/asgr_cfg.sv =====
module asgr_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [asgr_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [asgr_pkg::CFG_DATA_W-1:0]    wr_data,
    output asgr_pkg::cfg_t                     regs
);

    asgr_pkg::cfg_t cfg_reg;
    asgr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (asgr_pkg::cfg_index_t'(wr_index))
                asgr_pkg::CFG_ORIGIN_X:      cfg_next.origin_x      = wr_data[15:0];
                asgr_pkg::CFG_ORIGIN_Y:      cfg_next.origin_y      = wr_data[15:0];
                asgr_pkg::CFG_INITIAL_STYLE: cfg_next.initial_style = wr_data[1:0];
                asgr_pkg::CFG_INITIAL_COLOR: cfg_next.initial_color = wr_data[23:0];
                asgr_pkg::CFG_FONT_SIZE_PX:  cfg_next.font_size_px  = wr_data[7:0];
                asgr_pkg::CFG_WINDOW_WIDTH:  cfg_next.window_width  = wr_data[15:0];
                asgr_pkg::CFG_WINDOW_HEIGHT: cfg_next.window_height = wr_data[15:0];
                asgr_pkg::CFG_WRAP_ENABLE:   cfg_next.wrap_enable   = wr_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= asgr_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign regs = cfg_reg;

endmodule

// ===== rtl/asgr_esc.sv =====
module asgr_esc #(
    parameter int unsigned ESCAPE_BYTES = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic                          sos,
    input  logic                          run,
    input  logic [asgr_pkg::CODE_W-1:0]   code,
    output asgr_pkg::esc_res_t            res
);

    localparam int unsigned LEN_W = $clog2(ESCAPE_BYTES + 2);
    localparam int unsigned IDX_W = $clog2(ESCAPE_BYTES);

    localparam logic [7:0] B_LBRACKET = 8'h5B;
    localparam logic [7:0] B_ZERO     = 8'h30;
    localparam logic [7:0] B_ONE      = 8'h31;
    localparam logic [7:0] B_TWO      = 8'h32;
    localparam logic [7:0] B_THREE    = 8'h33;
    localparam logic [7:0] B_SEVEN    = 8'h37;
    localparam logic [7:0] B_NINE     = 8'h39;

    function automatic logic [23:0] normal_color(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0:    c = 24'h000000;
            3'd1:    c = 24'hCD0000;
            3'd2:    c = 24'h00CD00;
            3'd3:    c = 24'hCDCD00;
            3'd4:    c = 24'h0000EE;
            3'd5:    c = 24'hCD00CD;
            3'd6:    c = 24'h00CDCD;
            default: c = 24'hE5E5E5;
        endcase
        return c;
    endfunction

    function automatic logic [23:0] bright_color(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0:    c = 24'h7F7F7F;
            3'd1:    c = 24'hFF0000;
            3'd2:    c = 24'h00FF00;
            3'd3:    c = 24'hFFFF00;
            3'd4:    c = 24'h5C5CFF;
            3'd5:    c = 24'hFF00FF;
            3'd6:    c = 24'h00FFFF;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_eff;
    logic [7:0]       esc_byte_reg [ESCAPE_BYTES];

    logic             busy;
    logic             is_ctrl;
    logic             push;
    logic             clear;
    logic             digit;
    logic             n3;
    logic             n4;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [7:0]       b3;
    asgr_pkg::sgr_op_t dec_op;
    logic [23:0]      dec_color;

    always_comb
    begin
        // a new string starts with an empty buffer
        len_eff = sos ? '0 : len_reg;
        busy    = (len_eff != '0);
        is_ctrl = (code == asgr_pkg::CH_TAB) || (code == asgr_pkg::CH_LF) ||
                  (code == asgr_pkg::CH_VT)  || (code == asgr_pkg::CH_CR);
        push    = run && ((code == asgr_pkg::CH_ESC) ||
                          (busy && !is_ctrl && (code != asgr_pkg::CH_M)));
        clear   = run && busy && (code == asgr_pkg::CH_M);

        len_next = len_eff;
        if (push)
        begin
            // length stops one past the buffer so an overlong sequence stays bad
            if (len_eff <= LEN_W'(ESCAPE_BYTES))
            begin
                len_next = len_eff + 1'b1;
            end
        end
        else if (clear)
        begin
            len_next = '0;
        end
    end

    always_comb
    begin
        b1    = esc_byte_reg[1];
        b2    = esc_byte_reg[2];
        b3    = esc_byte_reg[3];
        n3    = (len_eff == LEN_W'(3));
        n4    = (len_eff == LEN_W'(4));
        digit = (b3 >= B_ZERO) && (b3 <= B_SEVEN);
        dec_color = 24'd0;
        dec_op    = asgr_pkg::SGR_BAD;
        if ((len_eff >= LEN_W'(3)) && (len_eff <= LEN_W'(ESCAPE_BYTES)) &&
            (b1 == B_LBRACKET))
        begin
            case (b2)
                B_ZERO: dec_op = asgr_pkg::SGR_RESET;
                B_ONE:  dec_op = asgr_pkg::SGR_BOLD;
                B_THREE:
                begin
                    if (n3)
                    begin
                        dec_op = asgr_pkg::SGR_ITALIC;
                    end
                    else if (n4 && digit)
                    begin
                        dec_op    = asgr_pkg::SGR_COLOR;
                        dec_color = normal_color(b3[2:0]);
                    end
                end
                B_NINE:
                begin
                    if (n4 && digit)
                    begin
                        dec_op    = asgr_pkg::SGR_COLOR;
                        dec_color = bright_color(b3[2:0]);
                    end
                end
                B_TWO:
                begin
                    if (n4 && ((b3 == B_ONE) || (b3 == B_TWO)))
                    begin
                        dec_op = asgr_pkg::SGR_NO_BOLD;
                    end
                    else if (n4 && (b3 == B_THREE))
                    begin
                        dec_op = asgr_pkg::SGR_NO_ITALIC;
                    end
                end
                default: dec_op = asgr_pkg::SGR_BAD;
            endcase
        end

        res.busy  = busy;
        res.op    = busy ? dec_op : asgr_pkg::SGR_NONE;
        res.color = dec_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (fire)
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && push && (len_eff < LEN_W'(ESCAPE_BYTES)))
        begin
            esc_byte_reg[len_eff[IDX_W-1:0]] <= code[7:0];
        end
    end

endmodule

// ===== rtl/asgr_core.sv =====
module asgr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  asgr_pkg::in_item_t   item,
    input  asgr_pkg::cfg_t       cfg,
    input  asgr_pkg::esc_res_t   esc,
    output logic                 run,
    output asgr_pkg::out_item_t  result
);

    function automatic logic [21:0] sat_x(input logic [22:0] s);
        return s[22] ? '1 : s[21:0];
    endfunction

    function automatic logic [15:0] sat_px(input logic [16:0] s);
        return s[16] ? '1 : s[15:0];
    endfunction

    function automatic logic [15:0] ceil_px(input logic [21:0] x);
        logic [22:0] t;
        t = {1'b0, x} + 23'd63;
        return sat_px(t[22:6]);
    endfunction

    logic [21:0] pen_x_reg, pen_x_next;
    logic [15:0] pen_y_reg, pen_y_next;
    logic [1:0]  style_reg, style_next;
    logic [23:0] color_reg, color_next;
    logic [15:0] right_reg, right_next;
    logic        halted_reg, halted_next;
    asgr_pkg::out_item_t result_reg, result_next;

    logic [21:0] origin_fx;
    logic [21:0] x0, x1, x2;
    logic [15:0] y0, y1, y2;
    logic [1:0]  st0, st1;
    logic [23:0] col0, col1;
    logic [15:0] rt0, rt1;
    logic        h0;
    logic        glyph;
    logic        bad;
    logic        stop;
    logic        draw;
    logic        wrap_hit;
    logic [15:0] adv;

    always_comb
    begin
        origin_fx = {cfg.origin_x, 6'b0};
        x0   = item.start_of_string ? origin_fx          : pen_x_reg;
        y0   = item.start_of_string ? cfg.origin_y       : pen_y_reg;
        st0  = item.start_of_string ? cfg.initial_style  : style_reg;
        col0 = item.start_of_string ? cfg.initial_color  : color_reg;
        rt0  = item.start_of_string ? cfg.origin_x       : right_reg;
        h0   = item.start_of_string ? 1'b0               : halted_reg;
        run  = !h0;

        x1 = x0;
        y1 = y0;
        st1 = st0;
        col1 = col0;
        rt1 = rt0;
        glyph = 1'b0;
        bad = 1'b0;

        if (run)
        begin
            case (item.char_code)
                asgr_pkg::CH_LF:
                begin
                    x1 = origin_fx;
                    y1 = sat_px({1'b0, y0} + 17'(cfg.font_size_px));
                end
                asgr_pkg::CH_CR:
                begin
                    x1 = origin_fx;
                end
                asgr_pkg::CH_TAB:
                begin
                    x1 = sat_x({1'b0, x0} + 23'({cfg.font_size_px, 8'b0}));
                    if (ceil_px(x1) > rt0)
                    begin
                        rt1 = ceil_px(x1);
                    end
                end
                asgr_pkg::CH_VT:
                begin
                    x1 = origin_fx;
                    y1 = sat_px({1'b0, y0} + 17'({cfg.font_size_px, 2'b0}));
                end
                asgr_pkg::CH_ESC:
                begin
                    // buffered by the escape collector
                end
                asgr_pkg::CH_M:
                begin
                    if (esc.busy)
                    begin
                        case (esc.op)
                            asgr_pkg::SGR_RESET:
                            begin
                                st1  = cfg.initial_style;
                                col1 = cfg.initial_color;
                            end
                            asgr_pkg::SGR_BOLD:      st1[0] = 1'b1;
                            asgr_pkg::SGR_ITALIC:    st1[1] = 1'b1;
                            asgr_pkg::SGR_COLOR:     col1   = esc.color;
                            asgr_pkg::SGR_NO_BOLD:   st1[0] = 1'b0;
                            asgr_pkg::SGR_NO_ITALIC: st1[1] = 1'b0;
                            asgr_pkg::SGR_BAD:       bad    = 1'b1;
                            default: ;
                        endcase
                    end
                    else
                    begin
                        glyph = 1'b1;
                    end
                end
                default:
                begin
                    glyph = !esc.busy;
                end
            endcase
        end

        // wrap before drawing, compared in 1/64 px
        wrap_hit = cfg.wrap_enable &&
                   (({1'b0, x1} + 23'({cfg.font_size_px, 6'b0})) >
                    23'({cfg.window_width, 6'b0}));
        x2 = x1;
        y2 = y1;
        if (glyph && wrap_hit)
        begin
            x2 = origin_fx;
            y2 = sat_px({1'b0, y1} + 17'(cfg.font_size_px));
        end

        stop = glyph && (y2 > cfg.window_height);
        draw = glyph && !stop;

        case (st1)
            2'd0:    adv = item.advance_regular;
            2'd1:    adv = item.advance_bold;
            2'd2:    adv = item.advance_italic;
            default: adv = item.advance_bold_italic;
        endcase

        pen_x_next  = x2;
        right_next  = rt1;
        if (draw)
        begin
            pen_x_next = sat_x({1'b0, x2} + 23'(adv));
            if (ceil_px(pen_x_next) > rt1)
            begin
                right_next = ceil_px(pen_x_next);
            end
        end
        pen_y_next  = y2;
        style_next  = st1;
        color_next  = col1;
        halted_next = h0 | stop;

        result_next.draw_glyph   = draw;
        result_next.pen_x        = x2;
        result_next.pen_y        = y2;
        result_next.style        = st1;
        result_next.color        = col1;
        result_next.area_right   = right_next;
        result_next.area_bottom  = sat_px({1'b0, y2} + 17'(cfg.font_size_px));
        result_next.stopped      = halted_next;
        result_next.bad_sequence = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            style_reg  <= '0;
            color_reg  <= '0;
            right_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else if (fire)
        begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            style_reg  <= style_next;
            color_reg  <= color_next;
            right_reg  <= right_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/asgr_checker.sv =====
`include "ansi_sgr_text_layout_macros.svh"

module asgr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  asgr_pkg::in_item_t                  item,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  asgr_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [asgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [asgr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // a held result keeps its payload
    `ASGR_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

    // a fresh result traces back to a character transaction through the input register
    `ASGR_ASSERT_IMPL(a_result_source, $rose(result_valid), $past(item_valid && !item_stall, 2))

    // the item side only backs up behind a stalled result
    `ASGR_ASSERT_IMPL(a_stall_cause, item_stall, result_valid && result_stall)

endmodule

bind ansi_sgr_text_layout asgr_checker u_asgr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);
